>>> src/multi_context_alu_register_file_unit_defines.svh
// Assertion macros used by the checker file of the register file unit.
`ifndef MULTI_CONTEXT_ALU_REGISTER_FILE_UNIT_DEFINES_SVH
`define MULTI_CONTEXT_ALU_REGISTER_FILE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCARF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCARF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/mcarf_pkg.sv
`default_nettype none

package mcarf_pkg;

   localparam int NUM_REGS    = 32;
   localparam int REG_BITS    = 5;
   localparam int DATA_BITS   = 32;
   localparam int CTX_BITS    = 2;
   localparam int OP_BITS     = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD  = 4'd0,
      OP_ADDI = 4'd1,
      OP_LI   = 4'd2,
      OP_SUB  = 4'd3,
      OP_MUL  = 4'd4,
      OP_AND  = 4'd5,
      OP_OR   = 4'd6,
      OP_XOR  = 4'd7,
      OP_ORI  = 4'd8,
      OP_SLL  = 4'd9,
      OP_SRL  = 4'd10,
      OP_DUMP = 4'd11
   } op_type;

   typedef enum logic {
      CLS_ALU,
      CLS_DUMP
   } cls_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic [CTX_BITS-1:0]  ctx;
      cls_type              cls;
      op_type               op;
      logic [REG_BITS-1:0]  dest;
      logic [REG_BITS-1:0]  src_a;
      logic [REG_BITS-1:0]  src_b;
      logic [DATA_BITS-1:0] imm;
   } item_type;

   typedef struct packed {
      logic clearing;
   } stat_type;

endpackage

`default_nettype wire

>>> src/mcarf_front.sv
`default_nettype none

module mcarf_front #(
   parameter int NUM_CONTEXTS = 4
) (
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mcarf_pkg::CTX_BITS-1:0]      req_context_id,
   input  logic [mcarf_pkg::OP_BITS-1:0]       req_opcode,
   input  logic [mcarf_pkg::REG_BITS-1:0]      req_dest_reg,
   input  logic [mcarf_pkg::REG_BITS-1:0]      req_src_a_reg,
   input  logic [mcarf_pkg::REG_BITS-1:0]      req_src_b_reg,
   input  logic signed [mcarf_pkg::DATA_BITS-1:0] req_immediate,
   input  logic                                q_ready,
   input  mcarf_pkg::stat_type                 stat,
   output logic                                q_push,
   output mcarf_pkg::item_type                 q_item
);
   import mcarf_pkg::*;

   logic keep_ctx;
   logic keep_op;

   // Words aimed at a missing context or carrying an unused opcode are taken and dropped.
   assign keep_ctx  = int'(req_context_id) < NUM_CONTEXTS;
   assign keep_op   = req_opcode <= OP_BITS'(OP_DUMP);
   assign req_ready = q_ready && !stat.clearing;
   assign q_push    = req_valid && req_ready && keep_ctx && keep_op;

   always_comb begin
      q_item.ctx   = req_context_id;
      q_item.cls   = (req_opcode == OP_BITS'(OP_DUMP)) ? CLS_DUMP : CLS_ALU;
      q_item.op    = op_type'(req_opcode);
      q_item.dest  = req_dest_reg;
      q_item.src_a = req_src_a_reg;
      q_item.src_b = req_src_b_reg;
      q_item.imm   = req_immediate;
   end

endmodule

`default_nettype wire

>>> src/mcarf_queue.sv
`default_nettype none

module mcarf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mcarf_pkg::item_type push_item,
   output logic                q_ready,
   output logic                q_valid,
   output mcarf_pkg::item_type head,
   input  logic                pop
);
   import mcarf_pkg::*;

   item_type              slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff;
   logic [QPTR_BITS-1:0]  wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff;
   logic [QPTR_BITS-1:0]  rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff;
   logic [QCNT_BITS-1:0]  count_in;

   assign q_ready = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign head    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> src/mcarf_back.sv
`default_nettype none

module mcarf_back #(
   parameter int NUM_CONTEXTS = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    q_valid,
   input  mcarf_pkg::item_type                     q_head,
   output logic                                    q_pop,
   output mcarf_pkg::stat_type                     stat,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [mcarf_pkg::REG_BITS-1:0]          rsp_reg_index,
   output logic signed [mcarf_pkg::DATA_BITS-1:0]  rsp_reg_value,
   output logic                                    rsp_is_dump,
   output logic                                    rsp_last
);
   import mcarf_pkg::*;

   localparam int DEPTH = NUM_CONTEXTS * NUM_REGS;
   localparam int AW    = $clog2(DEPTH);

   logic [DATA_BITS-1:0] mem [DEPTH];

   state_type            state_ff;
   state_type            state_in;
   item_type             item_ff;
   item_type             item_in;
   logic [REG_BITS-1:0]  idx_ff;
   logic [REG_BITS-1:0]  idx_in;
   logic [AW-1:0]        clr_cnt_ff;
   logic [AW-1:0]        clr_cnt_in;

   logic [DATA_BITS-1:0] rd_a_ff;
   logic [DATA_BITS-1:0] rd_b_ff;
   logic [AW-1:0]        rd_a_addr;
   logic [AW-1:0]        rd_b_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [DATA_BITS-1:0] wr_data;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [REG_BITS-1:0]  rsp_index_ff;
   logic [DATA_BITS-1:0] rsp_value_ff;
   logic                 rsp_dump_ff;
   logic                 rsp_last_ff;

   logic                 out_free;
   logic                 load;
   logic [REG_BITS-1:0]  ld_index;
   logic [DATA_BITS-1:0] ld_value;
   logic                 ld_dump;
   logic                 ld_last;

   logic [DATA_BITS-1:0] alu_res;
   logic [2*DATA_BITS-1:0] prod;
   logic [REG_BITS-1:0]  shamt;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign stat.clearing = state_ff == ST_CLEAR;

   assign prod  = (2*DATA_BITS)'(rd_a_ff) * (2*DATA_BITS)'(rd_b_ff);
   assign shamt = item_ff.imm[REG_BITS-1:0];

   always_comb begin
      case (item_ff.op)
         OP_ADD:  alu_res = rd_a_ff + rd_b_ff;
         OP_ADDI: alu_res = rd_a_ff + item_ff.imm;
         OP_LI:   alu_res = item_ff.imm;
         OP_SUB:  alu_res = rd_a_ff - rd_b_ff;
         OP_MUL:  alu_res = prod[DATA_BITS-1:0];
         OP_AND:  alu_res = rd_a_ff & rd_b_ff;
         OP_OR:   alu_res = rd_a_ff | rd_b_ff;
         OP_XOR:  alu_res = rd_a_ff ^ rd_b_ff;
         OP_ORI:  alu_res = rd_a_ff | item_ff.imm;
         OP_SLL:  alu_res = rd_a_ff << shamt;
         OP_SRL:  alu_res = rd_a_ff >> shamt;
         default: alu_res = '0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      idx_in     = idx_ff;
      clr_cnt_in = clr_cnt_ff;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = clr_cnt_ff;
      wr_data    = '0;
      rd_a_addr  = AW'({q_head.ctx, q_head.src_a});
      rd_b_addr  = AW'({q_head.ctx, q_head.src_b});
      load       = 1'b0;
      ld_index   = item_ff.dest;
      ld_value   = alu_res;
      ld_dump    = 1'b0;
      ld_last    = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_head;
               idx_in  = '0;
               if (q_head.cls == CLS_DUMP) begin
                  rd_a_addr = AW'({q_head.ctx, REG_BITS'(0)});
                  state_in  = ST_DUMP;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            rd_a_addr = AW'({item_ff.ctx, item_ff.src_a});
            rd_b_addr = AW'({item_ff.ctx, item_ff.src_b});
            if (out_free) begin
               load     = 1'b1;
               wr_en    = 1'b1;
               wr_addr  = AW'({item_ff.ctx, item_ff.dest});
               wr_data  = alu_res;
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            // The read port runs one register ahead so a word can leave every cycle while the output is free.
            rd_a_addr = AW'({item_ff.ctx, out_free ? idx_ff + 1'b1 : idx_ff});
            rd_b_addr = AW'({item_ff.ctx, item_ff.src_b});
            if (out_free) begin
               load     = 1'b1;
               ld_index = idx_ff;
               ld_value = rd_a_ff;
               ld_dump  = 1'b1;
               ld_last  = idx_ff == REG_BITS'(NUM_REGS - 1);
               idx_in   = idx_ff + 1'b1;
               if (ld_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (load) begin
         rsp_index_ff <= ld_index;
         rsp_value_ff <= ld_value;
         rsp_dump_ff  <= ld_dump;
         rsp_last_ff  <= ld_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reg_index = rsp_index_ff;
   assign rsp_reg_value = rsp_value_ff;
   assign rsp_is_dump   = rsp_dump_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

>>> src/multi_context_alu_register_file_unit.sv
// Channel   Direction  Handshake             Word
// req_      in         req_valid/req_ready   context, opcode, registers, immediate
// rsp_      out        rsp_valid/rsp_ready   register index, value, dump flag, last flag
//
// In the back end an ALU word is read from the register file when it leaves the queue, then
// executed and written back once the output is free. A dump reads register 0 first, then sends
// one word per cycle while the output is free for the 32 registers through a single read port.
// After reset a clearing pass zeroes the register files of all NUM_CONTEXTS contexts,
// during which req_ready is low.
// A two-entry queue lets the front keep taking words while rsp_ready is held low, until it fills.
`default_nettype none

module multi_context_alu_register_file_unit #(
   parameter int NUM_CONTEXTS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_context_id,
   input  logic [3:0]         req_opcode,
   input  logic [4:0]         req_dest_reg,
   input  logic [4:0]         req_src_a_reg,
   input  logic [4:0]         req_src_b_reg,
   input  logic signed [31:0] req_immediate,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_reg_index,
   output logic signed [31:0] rsp_reg_value,
   output logic               rsp_is_dump,
   output logic               rsp_last
);
   import mcarf_pkg::*;

   logic     q_ready;
   logic     q_push;
   logic     q_valid;
   logic     q_pop;
   item_type q_item;
   item_type q_head;
   stat_type stat;

   mcarf_front #(
      .NUM_CONTEXTS (NUM_CONTEXTS)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_context_id (req_context_id),
      .req_opcode     (req_opcode),
      .req_dest_reg   (req_dest_reg),
      .req_src_a_reg  (req_src_a_reg),
      .req_src_b_reg  (req_src_b_reg),
      .req_immediate  (req_immediate),
      .q_ready        (q_ready),
      .stat           (stat),
      .q_push         (q_push),
      .q_item         (q_item)
   );

   mcarf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .q_ready   (q_ready),
      .q_valid   (q_valid),
      .head      (q_head),
      .pop       (q_pop)
   );

   mcarf_back #(
      .NUM_CONTEXTS (NUM_CONTEXTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_reg_index (rsp_reg_index),
      .rsp_reg_value (rsp_reg_value),
      .rsp_is_dump   (rsp_is_dump),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

>>> src/mcarf_checker.sv
`default_nettype none
`include "multi_context_alu_register_file_unit_defines.svh"

module mcarf_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [4:0]         rsp_reg_index,
   input logic signed [31:0] rsp_reg_value,
   input logic               rsp_is_dump,
   input logic               rsp_last
);

   `MCARF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_reg_value) && $stable(rsp_reg_index) && $stable(rsp_last), "Stalled result word changed.")
   `MCARF_ASSERT_NOW(a_alu_last, clock, reset, rsp_valid && !rsp_is_dump, rsp_last, "ALU result word is not marked last.")
   `MCARF_ASSERT_NOW(a_dump_last, clock, reset, rsp_valid && rsp_is_dump, rsp_last == (rsp_reg_index == 5'd31), "Dump last flag does not match the final register.")
   `MCARF_ASSERT_NEXT(a_dump_step, clock, reset, rsp_valid && rsp_ready && rsp_is_dump && !rsp_last, rsp_valid && rsp_is_dump && (rsp_reg_index == $past(rsp_reg_index) + 5'd1), "Dump words do not follow in register order.")

endmodule

bind multi_context_alu_register_file_unit mcarf_checker u_mcarf_checker (.*);

`default_nettype wire

>>> sim/multi_context_alu_register_file_unit_tb.sv
`default_nettype none

module multi_context_alu_register_file_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcarf_pkg::*;

   localparam int CONTEXTS      = 4;
   localparam int RANDOM_WORDS  = 447;
   localparam int HOLD_AT       = 400;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 48;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [OP_BITS-1:0] OP_UNUSED_LO = 4'd12;
   localparam logic [OP_BITS-1:0] OP_UNUSED_HI = 4'd15;

   typedef struct {
      logic [CTX_BITS-1:0]  ctx;
      logic [OP_BITS-1:0]   opcode;
      logic [REG_BITS-1:0]  rd;
      logic [REG_BITS-1:0]  ra;
      logic [REG_BITS-1:0]  rb;
      logic [DATA_BITS-1:0] imm;
   } instr_type;

   typedef struct {
      logic [REG_BITS-1:0]  index;
      logic [DATA_BITS-1:0] value;
      logic                 dump;
      logic                 last;
   } report_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_context_id = '0;
   logic [3:0]         req_opcode = '0;
   logic [4:0]         req_dest_reg = '0;
   logic [4:0]         req_src_a_reg = '0;
   logic [4:0]         req_src_b_reg = '0;
   logic signed [31:0] req_immediate = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [4:0]         rsp_reg_index;
   logic signed [31:0] rsp_reg_value;
   logic               rsp_is_dump;
   logic               rsp_last;

   instr_type  instr_backlog[$];
   report_type reg_reports_due[$];
   logic [DATA_BITS-1:0] shadow_rf [CONTEXTS][NUM_REGS];
   instr_type  on_bus;

   int total_words = 0;
   int words_sent = 0;
   int dump_words = 0;
   int ignored_words = 0;
   int results_checked = 0;
   int fault_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   multi_context_alu_register_file_unit #(
      .NUM_CONTEXTS(CONTEXTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_context_id (req_context_id),
      .req_opcode     (req_opcode),
      .req_dest_reg   (req_dest_reg),
      .req_src_a_reg  (req_src_a_reg),
      .req_src_b_reg  (req_src_b_reg),
      .req_immediate  (req_immediate),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_reg_index  (rsp_reg_index),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_is_dump    (rsp_is_dump),
      .rsp_last       (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void add_instr(logic [1:0] ctx, logic [3:0] opcode, logic [4:0] rd,
                                     logic [4:0] ra, logic [4:0] rb, logic [31:0] imm);
      instr_type w;
      w = '{ctx, opcode, rd, ra, rb, imm};
      instr_backlog = {instr_backlog, w};
   endfunction

   function automatic logic [4:0] pick_reg();
      if ($urandom_range(99) < 60) begin
         return 5'($urandom_range(7));
      end
      return 5'($urandom_range(31));
   endfunction

   // Idle percentage by phase: sender light and receiver heavy, then swapped, then none.
   function automatic int idle_pct(bit receiver);
      int phase;
      phase = (total_words == 0) ? 0 : (words_sent * 3) / total_words;
      case (phase)
         0: return receiver ? 75 : 35;
         1: return receiver ? 35 : 75;
         default: return 0;
      endcase
   endfunction

   function automatic void apply_instruction(instr_type w);
      logic [DATA_BITS-1:0] a;
      logic [DATA_BITS-1:0] b;
      logic [DATA_BITS-1:0] res;
      logic [4:0]           sh;
      report_type           r;
      if (w.ctx >= CONTEXTS) begin
         ignored_words++;
         return;
      end
      a = shadow_rf[w.ctx][w.ra];
      b = shadow_rf[w.ctx][w.rb];
      sh = w.imm[4:0];
      case (w.opcode)
         OP_ADD:  res = a + b;
         OP_ADDI: res = a + w.imm;
         OP_LI:   res = w.imm;
         OP_SUB:  res = a - b;
         OP_MUL:  res = a * b;
         OP_AND:  res = a & b;
         OP_OR:   res = a | b;
         OP_XOR:  res = a ^ b;
         OP_ORI:  res = a | w.imm;
         OP_SLL:  res = a << sh;
         OP_SRL:  res = a >> sh;
         OP_DUMP: begin
            for (int i = 0; i < NUM_REGS; i++) begin
               r = '{5'(i), shadow_rf[w.ctx][i], 1'b1, (i == NUM_REGS - 1)};
               reg_reports_due = {reg_reports_due, r};
            end
            dump_words++;
            return;
         end
         default: begin
            ignored_words++;
            return;
         end
      endcase
      shadow_rf[w.ctx][w.rd] = res;
      r = '{w.rd, res, 1'b0, 1'b1};
      reg_reports_due = {reg_reports_due, r};
   endfunction

   function automatic void log_fault(string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_instruction(on_bus);
            words_sent <= words_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (instr_backlog.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
               on_bus = instr_backlog.pop_front();
               req_context_id <= on_bus.ctx;
               req_opcode     <= on_bus.opcode;
               req_dest_reg   <= on_bus.rd;
               req_src_a_reg  <= on_bus.ra;
               req_src_b_reg  <= on_bus.rb;
               req_immediate  <= on_bus.imm;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // A long hold-off of the receiver lets the block fill up and stall its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && words_sent >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      report_type got;
      report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_reg_index, rsp_reg_value, rsp_is_dump, rsp_last};
            results_checked++;
            if (reg_reports_due.size() == 0) begin
               log_fault($sformatf("unexpected word: index %0d value %h dump %b last %b",
                                   got.index, got.value, got.dump, got.last));
            end else begin
               want = reg_reports_due.pop_front();
               if (got.index !== want.index || got.value !== want.value ||
                   got.dump !== want.dump || got.last !== want.last) begin
                  log_fault($sformatf({"mismatch: expected index %0d value %h dump %b last %b,",
                                       " got index %0d value %h dump %b last %b"},
                                      want.index, want.value, want.dump, want.last,
                                      got.index, got.value, got.dump, got.last));
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
      end
   end

   initial begin
      int          pick;
      logic [1:0]  ctx;
      logic [3:0]  opcode;
      logic [31:0] imm;

      for (int c = 0; c < CONTEXTS; c++) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            shadow_rf[c][i] = '0;
         end
      end

      add_instr(2'd0, OP_LI,   5'd1,  5'd0,  5'd0,  32'h7FFF_FFFF);
      add_instr(2'd0, OP_LI,   5'd2,  5'd0,  5'd0,  32'h8000_0000);
      add_instr(2'd0, OP_LI,   5'd3,  5'd0,  5'd0,  32'hFFFF_FFFF);
      add_instr(2'd0, OP_ADD,  5'd4,  5'd1,  5'd3,  32'h0);
      add_instr(2'd0, OP_ADDI, 5'd5,  5'd1,  5'd0,  32'h1);
      add_instr(2'd0, OP_SUB,  5'd6,  5'd2,  5'd1,  32'h0);
      add_instr(2'd0, OP_MUL,  5'd7,  5'd1,  5'd1,  32'h0);
      add_instr(2'd0, OP_AND,  5'd8,  5'd2,  5'd3,  32'h0);
      add_instr(2'd0, OP_OR,   5'd9,  5'd1,  5'd2,  32'h0);
      add_instr(2'd0, OP_XOR,  5'd10, 5'd3,  5'd1,  32'h0);
      add_instr(2'd0, OP_ORI,  5'd11, 5'd0,  5'd0,  32'h8000_0001);
      add_instr(2'd0, OP_SLL,  5'd12, 5'd3,  5'd0,  32'd31);
      add_instr(2'd0, OP_SRL,  5'd13, 5'd3,  5'd0,  32'hFFFF_FFFF);
      add_instr(2'd0, OP_SRL,  5'd14, 5'd2,  5'd0,  32'h0000_0020);
      add_instr(2'd0, OP_LI,   5'd0,  5'd0,  5'd0,  32'h1234_5678);
      add_instr(2'd0, OP_ADDI, 5'd0,  5'd0,  5'd0,  32'hFFFF_FFF8);
      add_instr(2'd0, OP_UNUSED_LO, 5'd1, 5'd1, 5'd1, 32'hFFFF_FFFF);
      add_instr(2'd3, OP_UNUSED_HI, 5'd31, 5'd31, 5'd31, 32'h0);
      add_instr(2'd3, OP_LI,   5'd31, 5'd0,  5'd0,  32'hDEAD_BEEF);
      add_instr(2'd3, OP_SLL,  5'd30, 5'd31, 5'd31, 32'd4);
      add_instr(2'd0, OP_DUMP, 5'd0,  5'd0,  5'd0,  32'h0);
      add_instr(2'd3, OP_DUMP, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);
      add_instr(2'd1, OP_DUMP, 5'd0,  5'd0,  5'd0,  32'h0);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         pick = $urandom_range(99);
         ctx = 2'($urandom_range(3));
         if (pick < 4) begin
            opcode = OP_DUMP;
         end else if (pick < 7) begin
            opcode = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
         end else if (pick < 20) begin
            opcode = OP_LI;
         end else begin
            opcode = 4'($urandom_range(OP_SRL, OP_ADD));
         end
         case ($urandom_range(3))
            0: imm = 32'($urandom_range(63)) - 32'd32;
            1: imm = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: imm = $urandom;
         endcase
         add_instr(ctx, opcode, pick_reg(), pick_reg(), pick_reg(), imm);
      end
      total_words = instr_backlog.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (words_sent != total_words || reg_reports_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (reg_reports_due.size() != 0) begin
         log_fault($sformatf("%0d expected words never arrived", reg_reports_due.size()));
      end

      $display("Sent %0d words to %0d contexts (%0d dumps, %0d with unused opcodes).",
               words_sent, CONTEXTS, dump_words, ignored_words);
      $display("Checked %0d result words, with one receiver hold-off of %0d cycles; %0d faults.",
               results_checked, HOLD_CYCLES, fault_count);
      if (fault_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
